// ===== rtl/core/m4vt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and fixed constants of the 4x4 matrix vector transform core.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  // Width of every vector component and result component.
  localparam int DATA_W = 32;
  // Vector operands are split into two halves of this width for multiplication.
  localparam int HALF_W = 16;
  // Matrix dimension and coefficient count.
  localparam int N_DIM  = 4;
  localparam int N_COEF = 16;
  localparam int IDX_W  = 4;

  typedef enum logic {
    ACT_XFORM = 1'b0,
    ACT_LOAD  = 1'b1
  } m4vt_action_t;

  // Load enables for the two multiplier stages.
  typedef struct packed {
    logic ld_pp;
    logic ld_prod;
  } m4vt_mul_ctl_t;

  // Load enables for the three summation stages.
  typedef struct packed {
    logic ld_pair;
    logic ld_row;
    logic ld_out;
  } m4vt_sum_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/m4vt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_mul
// One coefficient times one vector component, in two register stages.
// ----------------------------------------------------------------------------
module m4vt_mul
  import m4vt_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire m4vt_mul_ctl_t                       ctl,
  input  wire logic signed [COEF_WIDTH-1:0]        coef,
  input  wire logic signed [DATA_W-1:0]            vec_elem,
  output logic signed [COEF_WIDTH+DATA_W-1:0]      prod_r
);

  localparam int PROD_W = COEF_WIDTH + DATA_W;

  // The operand is split so each multiplier stays near 17 bits on one side.
  logic signed [HALF_W-1:0]              x_hi;
  logic signed [HALF_W:0]                x_lo;
  logic signed [COEF_WIDTH+HALF_W-1:0]   pp_hi_r;
  logic signed [COEF_WIDTH+HALF_W:0]     pp_lo_r;
  logic signed [PROD_W-1:0]              prod_nxt;

  assign x_hi = vec_elem[DATA_W-1:HALF_W];
  assign x_lo = {1'b0, vec_elem[HALF_W-1:0]};

  always_ff @(posedge clk) begin
    if (ctl.ld_pp) begin
      pp_hi_r <= coef * x_hi;
      pp_lo_r <= coef * x_lo;
    end
  end

  assign prod_nxt = (PROD_W'(pp_hi_r) <<< HALF_W) + PROD_W'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/m4vt_row_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_row_sum
// Sums the four products of one matrix row, scales and saturates the result.
// ----------------------------------------------------------------------------
module m4vt_row_sum
  import m4vt_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire m4vt_sum_ctl_t                         ctl,
  input  wire logic signed [COEF_WIDTH+DATA_W-1:0]   prod [N_DIM],
  output logic signed [DATA_W-1:0]                   res_r
);

  localparam int PROD_W = COEF_WIDTH + DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [SUM_W-1:0]         pair0_r;
  logic signed [SUM_W-1:0]         pair1_r;
  logic signed [SUM_W-1:0]         row_r;
  logic signed [SUM_W-1:0]         shifted;
  logic        [SUM_W-1:DATA_W-1]  upper;
  logic signed [DATA_W-1:0]        res_nxt;

  always_ff @(posedge clk) begin
    if (ctl.ld_pair) begin
      pair0_r <= SUM_W'(prod[0]) + SUM_W'(prod[1]);
      pair1_r <= SUM_W'(prod[2]) + SUM_W'(prod[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_row) begin
      row_r <= pair0_r + pair1_r;
    end
  end

  // Arithmetic shift floors toward minus infinity; the value fits when all
  // bits from the result's sign bit upward agree.
  assign shifted = row_r >>> FRAC_BITS;
  assign upper   = shifted[SUM_W-1:DATA_W-1];

  always_comb begin
    if ((&upper) || (~|upper)) begin
      res_nxt = shifted[DATA_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/matrix4_vector_transform_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_vector_transform_core
// Streaming 4x4 matrix times 4-vector transform in signed fixed point.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   in_       input       in_valid/in_stall    action, coef_index, coef_value,
//                                              in_x, in_y, in_z, in_w
//   out_      output      out_valid/out_stall  out_x, out_y, out_z, out_w
//
// One beat is accepted per cycle while in_stall is low. A transform beat
// passes through the six-stage pipeline (input register, two multiplier
// stages, two adder stages, saturation and output register) to the output.
// A load beat writes its coefficient as it leaves the input register and
// produces no output beat.
// Reset (synchronous, active low) empties the pipeline and restores the
// identity matrix. A stall on the output freezes only the stages that are full
// behind it; bubbles ahead of a stall are squeezed out, and in_stall rises only
// when every stage holds a beat.
//
module matrix4_vector_transform_core
  import m4vt_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_action,
  input  wire logic [IDX_W-1:0]          in_coef_index,
  input  wire logic signed [DATA_W-1:0]  in_coef_value,
  input  wire logic signed [DATA_W-1:0]  in_x,
  input  wire logic signed [DATA_W-1:0]  in_y,
  input  wire logic signed [DATA_W-1:0]  in_z,
  input  wire logic signed [DATA_W-1:0]  in_w,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DATA_W-1:0]       out_x,
  output logic signed [DATA_W-1:0]       out_y,
  output logic signed [DATA_W-1:0]       out_z,
  output logic signed [DATA_W-1:0]       out_w
);

  localparam int PROD_W = COEF_WIDTH + DATA_W;
  // 1.0 in the coefficient format, kept in the low COEF_WIDTH bits.
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);

  // Stage valid bits; stage 6 is the output register.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt, v6_nxt;
  // A stage can take a beat when it is empty or its own beat moves on.
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // Input register payload.
  m4vt_action_t             s1_act_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [DATA_W-1:0] s1_val_r;
  logic signed [DATA_W-1:0] s1_vec_r [N_DIM];

  logic signed [COEF_WIDTH-1:0] coef_r [N_COEF];
  logic signed [COEF_WIDTH-1:0] coef_nxt;
  logic signed [63:0]           coef_ext;
  logic                         coef_we;

  logic signed [PROD_W-1:0] prod [N_DIM][N_DIM];
  logic signed [DATA_W-1:0] res  [N_DIM];

  m4vt_mul_ctl_t mul_ctl;
  m4vt_sum_ctl_t sum_ctl;

  // Ready chain, from the output back to the input.
  assign rdy6 = !v6_r || !out_stall;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = v6_r;

  // Load beats drop out of the valid chain when they leave the input register.
  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? (v1_r && (s1_act_r == ACT_XFORM)) : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
    v5_nxt = rdy5 ? v4_r : v5_r;
    v6_nxt = rdy6 ? v5_r : v6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_act_r    <= m4vt_action_t'(in_action);
      s1_idx_r    <= in_coef_index;
      s1_val_r    <= in_coef_value;
      s1_vec_r[0] <= in_x;
      s1_vec_r[1] <= in_y;
      s1_vec_r[2] <= in_z;
      s1_vec_r[3] <= in_w;
    end
  end

  // The matrix is read and written from the same stage, so every transform
  // sees exactly the loads that were accepted ahead of it.
  assign coef_we  = v1_r && (s1_act_r == ACT_LOAD) && rdy2;
  assign coef_ext = 64'(s1_val_r);
  assign coef_nxt = coef_ext[COEF_WIDTH-1:0];

  for (genvar i = 0; i < N_COEF; i++) begin : g_coef
    localparam bit IS_DIAG = (i % (N_DIM + 1)) == 0;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[i] <= IS_DIAG ? COEF_ONE : '0;
      end else if (coef_we && (s1_idx_r == IDX_W'(i))) begin
        coef_r[i] <= coef_nxt;
      end
    end
  end

  assign mul_ctl.ld_pp   = rdy2 && v1_r && (s1_act_r == ACT_XFORM);
  assign mul_ctl.ld_prod = rdy3 && v2_r;
  assign sum_ctl.ld_pair = rdy4 && v3_r;
  assign sum_ctl.ld_row  = rdy5 && v4_r;
  assign sum_ctl.ld_out  = rdy6 && v5_r;

  // Sixteen multiplier lanes, one per coefficient.
  for (genvar r = 0; r < N_DIM; r++) begin : g_row
    for (genvar c = 0; c < N_DIM; c++) begin : g_col
      m4vt_mul #(
        .COEF_WIDTH (COEF_WIDTH)
      ) u_mul (
        .clk      (clk),
        .ctl      (mul_ctl),
        .coef     (coef_r[r*N_DIM+c]),
        .vec_elem (s1_vec_r[c]),
        .prod_r   (prod[r][c])
      );
    end

    m4vt_row_sum #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_row_sum (
      .clk   (clk),
      .ctl   (sum_ctl),
      .prod  (prod[r]),
      .res_r (res[r])
    );
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

`ifndef SYNTHESIS
  // A load beat must never enter the arithmetic stages.
  a_load_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && (s1_act_r == ACT_LOAD) && rdy2) |=> !v2_r)
    else $error("load beat entered the multiplier stage");

  // Backpressure reaches the input only when the whole pipeline is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_stall && v1_r && v2_r && v3_r && v4_r && v5_r && v6_r))
    else $error("input stalled with an empty stage");

  // A finished row sum moving into an open output register shows up there.
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && rdy6) |=> out_valid)
    else $error("result lost between saturation and output");

  // Output beats held under stall keep their data; out_x and out_w are checked.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_x) && $stable(out_w)))
    else $error("stalled output changed");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 matrix vector transform core: a directed
// opening of identity, extreme and rounding cases, then a random mix of
// coefficient loads and vertex transforms checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import m4vt_pkg::*;

  localparam int COEF_W    = 32;
  localparam int FRAC      = 16;
  // A dot product of four 32x32 products needs 66 bits; one spare keeps the
  // sign safe through the arithmetic shift.
  localparam int ACC_W     = 2 * DATA_W + 3;
  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  localparam int N_RANDOM      = 500;
  localparam int IDLE_PCT      = 18;
  // Both sides run without gaps while this window of beats is accepted.
  localparam int QUIET_FROM    = 200;
  localparam int QUIET_TO      = 300;
  // After this many results the receiver holds off long enough to fill the
  // six-stage pipeline and push in_stall high.
  localparam int HOLD_AT       = 100;
  localparam int HOLD_CYCLES   = 48;
  localparam int DRAIN_CYCLES  = 12;
  localparam int WATCHDOG_MAX  = 1000;

  // One input beat as the sender offers it.
  typedef struct packed {
    m4vt_action_t                   act;
    logic [IDX_W-1:0]               idx;
    logic [DATA_W-1:0]              coef;
    logic [N_DIM-1:0][DATA_W-1:0]   vec;   // [0]=x .. [3]=w
  } vertex_beat_t;

  // One transformed vertex.
  typedef struct packed {
    logic [N_DIM-1:0][DATA_W-1:0]   comp;  // [0]=x .. [3]=w
  } vertex_out_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block ports; the inputs driven by the bench are known from time zero.
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic                      in_action     = ACT_XFORM;
  logic [IDX_W-1:0]          in_coef_index = '0;
  logic signed [DATA_W-1:0]  in_coef_value = '0;
  logic signed [DATA_W-1:0]  in_x          = '0;
  logic signed [DATA_W-1:0]  in_y          = '0;
  logic signed [DATA_W-1:0]  in_z          = '0;
  logic signed [DATA_W-1:0]  in_w          = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic signed [DATA_W-1:0]  out_x;
  logic signed [DATA_W-1:0]  out_y;
  logic signed [DATA_W-1:0]  out_z;
  logic signed [DATA_W-1:0]  out_w;

  logic [N_DIM-1:0][DATA_W-1:0] out_vec;
  assign out_vec = {out_w, out_z, out_y, out_x};

  matrix4_vector_transform_core #(
    .COEF_WIDTH (COEF_W),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_z          (in_z),
    .in_w          (in_w),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w)
  );

  // Bench state: the beats still to send, the shadow copy of the matrix and
  // the transformed vertices still owed by the block, oldest first.
  vertex_beat_t              pending_beats[$];
  vertex_out_t               expected_vertices[$];
  logic signed [COEF_W-1:0]  coef_mem [N_COEF];

  int n_accepted    = 0;
  int n_results     = 0;
  int n_errors      = 0;
  int n_loads       = 0;
  int n_xforms      = 0;
  int n_saturated   = 0;
  int n_backpressed = 0;
  int idle_cycles   = 0;

  logic quiet;
  assign quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

  // Multiply the shadow matrix by one vector. Each row sums its four full
  // products exactly, shifts right arithmetically (rounding toward minus
  // infinity) and clamps to the signed 32-bit range.
  function automatic vertex_out_t transform_vertex(input logic [N_DIM-1:0][DATA_W-1:0] v);
    vertex_out_t              res;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;
    for (int row = 0; row < N_DIM; row++) begin
      acc = '0;
      for (int col = 0; col < N_DIM; col++) begin
        acc = acc + coef_mem[row * N_DIM + col] * $signed(v[col]);
      end
      scaled = acc >>> FRAC;
      // The value fits when every bit above bit 31 matches the sign bit.
      if (&scaled[ACC_W-1:DATA_W-1] || ~|scaled[ACC_W-1:DATA_W-1]) begin
        res.comp[row] = scaled[DATA_W-1:0];
      end else begin
        res.comp[row] = scaled[ACC_W-1] ? Q_MIN : Q_MAX;
        n_saturated++;
      end
    end
    return res;
  endfunction

  // Advance the shadow model by one beat. Loads take effect in order with
  // transforms because the pipeline never reorders beats.
  function automatic void step_transform_model(input vertex_beat_t b);
    if (b.act == ACT_LOAD) begin
      coef_mem[b.idx] = $signed(b.coef);
      n_loads++;
    end else begin
      expected_vertices.push_back(transform_vertex(b.vec));
      n_xforms++;
    end
  endfunction

  // A Q16.16 value drawn from a mix: full-range noise for bit coverage, small
  // magnitudes so that most sums stay unsaturated, whole numbers and extremes.
  function automatic logic [DATA_W-1:0] pick_q16();
    int unsigned        sel;
    logic [DATA_W-1:0]  r;
    sel = $urandom_range(99);
    r   = $urandom();
    if (sel < 30) return r;
    if (sel < 75) return {{(DATA_W-20){r[19]}}, r[19:0]};
    if (sel < 90) return DATA_W'((int'($urandom_range(16)) - 8) * 65536);
    case (r[1:0])
      2'd0:    return Q_MAX;
      2'd1:    return Q_MIN;
      2'd2:    return '0;
      default: return '1;
    endcase
  endfunction

  // Queue helpers; fields the block ignores for the beat get random values.
  task automatic add_load(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    vertex_beat_t b;
    b.act  = ACT_LOAD;
    b.idx  = idx;
    b.coef = val;
    b.vec  = {$urandom(), $urandom(), $urandom(), $urandom()};
    pending_beats.push_back(b);
  endtask

  task automatic add_xform(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                           input logic [DATA_W-1:0] z, input logic [DATA_W-1:0] w);
    vertex_beat_t b;
    b.act  = ACT_XFORM;
    b.idx  = IDX_W'($urandom());
    b.coef = $urandom();
    b.vec  = {w, z, y, x};
    pending_beats.push_back(b);
  endtask

  // Sender. A new beat is put on the pins only when the previous one was
  // taken or nothing was offered, so a stalled beat stays put. The model is
  // stepped as a beat is first driven; the block cannot answer it sooner.
  vertex_beat_t drive_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && in_stall) begin
        n_backpressed <= n_backpressed + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          drive_beat = pending_beats.pop_front();
          step_transform_model(drive_beat);
          in_valid      <= 1'b1;
          in_action     <= drive_beat.act;
          in_coef_index <= drive_beat.idx;
          in_coef_value <= drive_beat.coef;
          in_x          <= drive_beat.vec[0];
          in_y          <= drive_beat.vec[1];
          in_z          <= drive_beat.vec[2];
          in_w          <= drive_beat.vec[3];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every accepted result beat is checked component by component
  // against the oldest owed vertex. The stall pattern is random, quiet inside
  // the no-idle window, and once holds off for a long stretch of cycles.
  vertex_out_t want;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  string       comp_name [N_DIM] = '{"x", "y", "z", "w"};

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_vertices.size() == 0) begin
          $display("%0t: result beat with none expected: x=%h y=%h z=%h w=%h",
                   $time, out_x, out_y, out_z, out_w);
          n_errors++;
        end else begin
          want = expected_vertices.pop_front();
          for (int c = 0; c < N_DIM; c++) begin
            if (out_vec[c] !== want.comp[c]) begin
              $display("%0t: out_%s expected %h, actual %h",
                       $time, comp_name[c], want.comp[c], out_vec[c]);
              n_errors++;
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without a beat moving on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < N_COEF; i++) begin
      coef_mem[i] = (i % (N_DIM + 1) == 0) ? $signed(Q_ONE) : '0;
    end

    // Identity matrix straight after reset, with extreme components.
    add_xform(Q_ONE, 32'hFFFF_0000, Q_MAX, Q_MIN);
    add_xform('0, '1, 32'h0000_0001, Q_MAX);
    // Extreme coefficients at the first and last index, plus a tiny one in
    // row 1 so that a product of -1 shows the floor rounding of the shift.
    add_load(4'd0, Q_MAX);
    add_load(4'd15, Q_MIN);
    add_load(4'd5, 32'h0000_0001);
    // Row 0 overflows positive, row 1 gives -1, row 3 overflows negative.
    add_xform(Q_MAX, '1, '0, Q_MAX);
    // All-minimum vector: row 0 saturates low, row 3 saturates high.
    add_xform(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    // Affine point: a translation in column 3 applied with w at 1.0.
    add_load(4'd0, Q_ONE);
    add_load(4'd5, Q_ONE);
    add_load(4'd15, Q_ONE);
    add_load(4'd3, 32'hFFFF_0000);
    add_load(4'd7, 32'h0002_8000);
    add_load(4'd11, 32'h7FFF_0000);
    add_xform(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, Q_ONE);
    // Negative fractions round toward minus infinity.
    add_load(4'd10, 32'h0000_8000);
    add_xform('1, '1, 32'hFFFF_FFFD, '1);
    add_xform(Q_MAX, Q_MIN, Q_MAX, Q_ONE);

    // Random part: mostly transforms, some coefficient loads; w is often 1.0
    // as it is for points.
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(99) < 20) begin
        add_load(IDX_W'($urandom()), pick_q16());
      end else begin
        add_xform(pick_q16(), pick_q16(), pick_q16(),
                  ($urandom_range(99) < 40) ? Q_ONE : pick_q16());
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge, clear of the clocked processes.
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_vertices.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d coefficient loads and %0d transforms (%0d saturated components).",
             n_loads, n_xforms, n_saturated);
    $display("Input was held back by in_stall in %0d cycles; %0d result beats checked.",
             n_backpressed, n_results);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/m4vt_pkg.sv
rtl/core/m4vt_mul.sv
rtl/core/m4vt_row_sum.sv
rtl/core/matrix4_vector_transform_core.sv
sim/tb_top.sv
